/* sv/lru_key_value_cache_assert.svh */
// ----------------------------------------------------------------------------
// LRU key/value cache assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// Property that must hold at every clock edge out of reset
`define LKV_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked in the cycle after the antecedent
`define LKV_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/lkv_pkg.sv */
// ----------------------------------------------------------------------------
// LRU key/value cache package
// Sizes, operation codes and the entry record that moves along the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package lkv_pkg;

  localparam int unsigned ENTRIES   = 16;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned CAP_W     = 5;
  localparam int unsigned CNT_W     = $clog2(ENTRIES + 1);
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Operation carried in tuser
  typedef enum logic {
    ACT_GET = 1'b0,
    ACT_PUT = 1'b1
  } action_e;

  // One cache entry
  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } entry_t;

endpackage

`default_nettype wire

/* sv/lkv_cell.sv */
// ----------------------------------------------------------------------------
// LRU key/value cache cell
// One slot of the recency-ordered chain: holds an entry, compares it against
// the lookup key and takes its neighbor's entry when told to shift.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_cell import lkv_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             shift_i,   // load entry_i this cycle
  input  wire entry_t           entry_i,   // entry from the more recent neighbor
  input  wire logic [KEY_W-1:0] key_i,     // lookup key
  output logic                  match_o,
  output entry_t                entry_o
);

  logic               valid_q;
  logic [KEY_W-1:0]   key_q;
  logic [VALUE_W-1:0] value_q;

  // Valid mark, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= entry_i.valid;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      key_q   <= entry_i.key;
      value_q <= entry_i.value;
    end
  end

  // Key compare
  assign match_o = valid_q && (key_q == key_i);

  assign entry_o = '{valid: valid_q, key: key_q, value: value_q};

endmodule

`default_nettype wire

/* sv/lru_key_value_cache.sv */
// ----------------------------------------------------------------------------
// LRU key/value cache
// Fully associative key/value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// The entries sit in a chain of cells kept in recency order: cell 0 holds the
// most recent entry and the live entries fill the chain from cell 0 without
// gaps. Each transaction on the slave side is a get (tuser = 0) or a put
// (tuser = 1). All cells compare the key at once; a hit, or an insert, moves
// the entry to cell 0 while the cells ahead of it shift one place down, and an
// insert at capacity drops the last live cell, whose key is reported. Every
// transaction goes through the compare-and-shift step and yields one result
// in an output register, so one item per cycle is sustained while the master
// side takes results. The user must write capacity only while the block is
// idle (the block does not enforce this); zero counts as 1, above 16 as 16.
`default_nettype none

`include "lru_key_value_cache_assert.svh"

module lru_key_value_cache import lkv_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // Configuration
  input  wire logic             cfg_we_i,
  input  wire logic [CAP_W-1:0] cfg_wdata_i,     // capacity
  // Slave side
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [63:0]      s_axis_tdata,    // [31:0] key, [63:32] write_value
  input  wire logic [0:0]       s_axis_tuser,    // [0] action
  // Master side
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [63:0]           m_axis_tdata,    // [31:0] read_value, [63:32] evicted_key
  output logic [1:0]            m_axis_tuser     // [0] hit, [1] evicted
);

  logic [CAP_W-1:0] cap_q;
  logic [CNT_W-1:0] count_q, eff_cap;

  logic               accept;
  action_e            action;
  logic [KEY_W-1:0]   key;
  logic [VALUE_W-1:0] wval;

  entry_t               cell_in  [ENTRIES];
  entry_t               cell_out [ENTRIES];
  logic [ENTRIES-1:0]   match, valid_vec, last_vec, sel_vec, shift_vec;
  logic                 hit, do_insert, do_evict, do_shift;
  logic [VALUE_W-1:0]   hit_value;
  logic [KEY_W-1:0]     evict_key;
  entry_t               head;

  logic        out_valid_q;
  logic [63:0] out_data_q;
  logic [1:0]  out_user_q;

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  assign eff_cap = (cap_q == '0)                ? CNT_W'(1) :
                   (cap_q > CAP_W'(ENTRIES))    ? CNT_W'(ENTRIES) : CNT_W'(cap_q);

  // Input unpacking
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign action        = action_e'(s_axis_tuser[0]);
  assign key           = s_axis_tdata[KEY_W-1:0];
  assign wval          = s_axis_tdata[63:32];

  // Cell chain
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cell_in[i] = head;
    end else begin : g_link
      assign cell_in[i] = cell_out[i-1];
    end

    lkv_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift_vec[i]),
      .entry_i (cell_in[i]),
      .key_i   (key),
      .match_o (match[i]),
      .entry_o (cell_out[i])
    );

    assign valid_vec[i] = cell_out[i].valid;

    // Last live cell holds the least recent entry
    if (i == ENTRIES - 1) begin : g_tail
      assign last_vec[i] = valid_vec[i];
    end else begin : g_mid
      assign last_vec[i] = valid_vec[i] && !cell_out[i+1].valid;
    end
  end

  // Operation decode
  assign hit       = |match;
  assign do_insert = (action == ACT_PUT) && !hit;
  assign do_evict  = do_insert && (count_q >= eff_cap);
  assign do_shift  = accept && (hit || do_insert);

  // Hit value and evicted key, one-hot selects
  always_comb begin
    hit_value = '0;
    evict_key = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_value = hit_value | ({VALUE_W{match[i]}} & cell_out[i].value);
      evict_key = evict_key | ({KEY_W{last_vec[i]}} & cell_out[i].key);
    end
  end

  // Cells up to the selected one shift one place down
  always_comb begin
    priority if (hit) begin
      sel_vec = match;
    end else if (do_evict) begin
      sel_vec = last_vec;
    end else begin
      sel_vec = '1;
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      shift_vec[i] = do_shift && |(sel_vec & ~((ENTRIES'(1) << i) - ENTRIES'(1)));
    end
  end

  // New most recent entry
  assign head = '{valid: 1'b1,
                  key:   key,
                  value: (hit && action == ACT_GET) ? hit_value : wval};

  // Live count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept && do_insert && !do_evict) begin
      count_q <= count_q + CNT_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q[31:0]  <= (hit && action == ACT_GET) ? hit_value : '1;
      out_data_q[63:32] <= do_evict ? evict_key : '0;
      out_user_q        <= {do_evict, hit};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // Assertions
  `LKV_ASSERT(a_unique_key, $onehot0(match), "key present in more than one cell")
  `LKV_ASSERT(a_live_count, $countones(valid_vec) == int'(count_q), "live count mismatch")
  `LKV_ASSERT(a_packed_chain, ((valid_vec + ENTRIES'(1)) & valid_vec) == '0, "gap in chain")
  `LKV_ASSERT_NEXT(a_evict_keeps, accept && do_evict, $stable(count_q), "count moved on evict")

endmodule

`default_nettype wire

/* bench/tb_lru_key_value_cache.sv */
// ----------------------------------------------------------------------------
// LRU key/value cache testbench
// Drives get/put transactions into the cache and predicts each result with a
// recency-ordered list: a hit moves its line to the front, an insert at the
// usable capacity drops the line at the back. Covers key/value extremes, the
// capacity register at its limits and out of range, capacity shrink below the
// live count, output backpressure, sender pauses and back-to-back traffic.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache;
  import lkv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned SINK_HOLD_CYCLES = 200;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES = 20;

  // One stored line of the predicted cache
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } cache_line_t;

  // Expected result of one lookup
  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] read_value;
    logic               evicted;
    logic [KEY_W-1:0]   evicted_key;
  } lookup_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [CAP_W-1:0] cfg_wdata_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [63:0]      s_axis_tdata = '0;   // [31:0] key, [63:32] write_value
  logic [0:0]       s_axis_tuser = '0;   // [0] action
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [63:0]      m_axis_tdata;        // [31:0] read_value, [63:32] evicted_key
  logic [1:0]       m_axis_tuser;        // [0] hit, [1] evicted

  // Predictor state: index 0 is the most recent line
  cache_line_t      recency_list[$];
  logic [CAP_W-1:0] capacity_reg = CAP_RESET;
  lookup_result_t   pending_results[$];

  int unsigned error_count = 0;
  int unsigned stall_cycles = 0;
  bit          src_idle_en = 1'b1;
  bit          sink_idle_en = 1'b1;
  bit          sink_hold_req = 1'b0;

  lru_key_value_cache dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Zero counts as one entry, anything above the array size as the full array
  function automatic int unsigned usable_entries();
    if (capacity_reg == 0) return 1;
    if (capacity_reg > ENTRIES) return ENTRIES;
    return 32'(capacity_reg);
  endfunction

  // Apply one get/put to the predicted cache and return its result
  function automatic lookup_result_t predict_lookup(action_e act, logic [KEY_W-1:0] key,
                                                    logic [VALUE_W-1:0] wval);
    lookup_result_t res;
    cache_line_t    line;
    int             slot;
    res.hit = 1'b0;
    res.read_value = '1;
    res.evicted = 1'b0;
    res.evicted_key = '0;
    slot = -1;
    foreach (recency_list[i])
      if (slot < 0 && recency_list[i].key == key) slot = i;
    if (slot >= 0) begin
      res.hit = 1'b1;
      line = recency_list[slot];
      if (act == ACT_GET) res.read_value = line.value;
      else line.value = wval;
      recency_list.delete(slot);
      recency_list.push_front(line);
    end else if (act == ACT_PUT) begin
      // Full (or over a lowered capacity): drop exactly one line, the oldest
      if (recency_list.size() >= usable_entries()) begin
        line = recency_list.pop_back();
        res.evicted = 1'b1;
        res.evicted_key = line.key;
      end
      line.key = key;
      line.value = wval;
      recency_list.push_front(line);
    end
    return res;
  endfunction

  function automatic void check_field(string field_name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%08h, actual 0x%08h", field_name, want, got);
      error_count++;
    end
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    lookup_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no request outstanding");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("hit", 32'(want.hit), 32'(m_axis_tuser[0]));
        check_field("read_value", want.read_value, m_axis_tdata[31:0]);
        check_field("evicted", 32'(want.evicted), 32'(m_axis_tuser[1]));
        check_field("evicted_key", want.evicted_key, m_axis_tdata[63:32]);
      end
    end
  end

  // Result sink: random stall bursts, or one long hold when asked
  initial begin
    forever begin
      @(posedge clk_i);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (SINK_HOLD_CYCLES - 1) @(posedge clk_i);
      end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 8)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offer one request, wait for its transaction, record its expected result
  task automatic send_item(action_e act, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] wval);
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {wval, key};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.insert(pending_results.size(), predict_lookup(act, key, wval));
  endtask

  // Stop offering and wait until every result is back
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] cap);
    wait_for_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    capacity_reg = cap;
    cfg_we_i <= 1'b0;
  endtask

  // Random gets/puts over a key pool a bit larger than the usable capacity
  task automatic run_random_traffic(int unsigned n_items);
    logic [KEY_W-1:0] key_pool[$];
    logic [KEY_W-1:0] key;
    int unsigned      pool_size;
    pool_size = usable_entries() + $urandom_range(1, 6);
    repeat (pool_size) key_pool.insert(key_pool.size(), $urandom);
    repeat (n_items) begin
      if ($urandom_range(0, 9) == 0) key = $urandom;
      else key = key_pool[$urandom_range(0, pool_size - 1)];
      send_item(action_e'($urandom_range(0, 1)), key, $urandom);
    end
  endtask

  // Extremes of key and value, misses, hits, updates, get ignoring its value
  task automatic test_basic_ops();
    send_item(ACT_GET, 32'h0000_0000, 32'h0000_0000);
    send_item(ACT_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    send_item(ACT_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(ACT_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(ACT_PUT, 32'h0000_0000, 32'h0000_0000);
    send_item(ACT_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(ACT_GET, 32'h8000_0000, 32'h1234_5678);
    send_item(ACT_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send_item(ACT_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(ACT_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    // update of a present key: hit, no eviction
    send_item(ACT_PUT, 32'h0000_0000, 32'h5A5A_5A5A);
    send_item(ACT_GET, 32'h0000_0000, 32'h0000_0000);
    send_item(ACT_GET, 32'h1234_5678, 32'h0000_0000);
  endtask

  // Capacity dropped under the live count: each insert evicts one line only
  task automatic test_capacity_shrink();
    set_capacity(CAP_W'(2));
    send_item(ACT_PUT, 32'hA5A5_0001, 32'h0000_0011);
    send_item(ACT_PUT, 32'hA5A5_0002, 32'h0000_0022);
    send_item(ACT_GET, 32'h8000_0000, 32'h0000_0000);
    send_item(ACT_PUT, 32'hA5A5_0003, 32'h0000_0033);
    send_item(ACT_PUT, 32'h0000_0000, 32'hCAFE_F00D);
    send_item(ACT_GET, 32'hA5A5_0001, 32'h0000_0000);
    send_item(ACT_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(ACT_PUT, 32'hA5A5_0004, 32'h0000_0044);
    send_item(ACT_PUT, 32'hA5A5_0005, 32'h0000_0055);
    send_item(ACT_GET, 32'hA5A5_0005, 32'h0000_0000);
  endtask

  // Random traffic across in-range, zero and oversized capacities
  task automatic test_capacity_sweep();
    logic [CAP_W-1:0] caps[7] = '{CAP_W'(1), CAP_W'(0), CAP_W'(31), CAP_W'(17),
                                  CAP_W'(3), CAP_W'(8), CAP_W'(16)};
    foreach (caps[i]) begin
      set_capacity(caps[i]);
      run_random_traffic(150);
    end
  endtask

  // Long output stall while requests keep coming, so the input stalls too
  task automatic test_output_backpressure();
    set_capacity(CAP_W'(6));
    src_idle_en = 1'b0;
    sink_hold_req = 1'b1;
    run_random_traffic(60);
    src_idle_en = 1'b1;
  endtask

  // Short bursts, each followed by a full drain of results
  task automatic test_sender_pause();
    set_capacity(CAP_W'(12));
    repeat (10) begin
      run_random_traffic(10);
      wait_for_results();
    end
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_full_rate();
    set_capacity(CAP_W'(16));
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    run_random_traffic(400);
  endtask

  // Test sequence
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_ops();
    test_capacity_shrink();
    test_capacity_sweep();
    test_output_backpressure();
    test_sender_pause();
    test_full_rate();
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
